[src/bpa_pkg.sv]
`timescale 1ns / 1ps
// bpa_pkg: constants, types and helper functions of the buddy page allocator.
// No dependencies.
package bpa_pkg;

    localparam int MaxPages  = 2048;
    localparam int TopOrder  = 11;
    localparam int PageBytes = 4096;
    localparam int IdxW      = $clog2(MaxPages);
    localparam int LinkW     = IdxW + 1;
    localparam int OrdN      = TopOrder + 1;
    localparam int OrdW      = $clog2(OrdN);
    localparam int PageSh    = $clog2(PageBytes);
    localparam int AddrW     = 64;
    localparam int SizeW     = 32;
    localparam int FreeW     = 12;
    localparam logic [LinkW-1:0] NoneLink = LinkW'(MaxPages);

    typedef enum logic [1:0] {
        ACT_ALLOC,
        ACT_FREE,
        ACT_INIT,
        ACT_NOP
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE,
        ST_ZERO,
        ST_BIG,
        ST_NOBLK,
        ST_OUT,
        ST_DFREE
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ASRCH,
        S_ASPL,
        S_FCHK,
        S_ICLR,
        S_ISEL,
        S_INXT,
        S_RELT,
        S_RELC,
        S_RELM,
        S_RMRD,
        S_RMWR,
        S_PU1,
        S_PU2,
        S_MARK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_state op;
        logic   accept;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    dec_fail;
        logic    srch_hit;
        logic    spl_more;
        logic    fchk_ok;
        logic    clr_done;
        logic    rem_zero;
        logic    rel_stop;
        logic    rel_merge;
        logic    mark_last;
    } t_sts;

    function automatic logic [OrdW-1:0] f_bitlen(input logic [IdxW-1:0] v);
        logic [OrdW-1:0] r;
        r = '0;
        for (int i = 0; i < IdxW; i++) begin
            if (v[i]) r = OrdW'(i + 1);
        end
        return r;
    endfunction

    function automatic logic [OrdW-1:0] f_msb(input logic [LinkW-1:0] v);
        logic [OrdW-1:0] r;
        r = '0;
        for (int i = 0; i < LinkW; i++) begin
            if (v[i]) r = OrdW'(i);
        end
        return r;
    endfunction

    function automatic logic [OrdW-1:0] f_tz(input logic [IdxW-1:0] v);
        logic [OrdW-1:0] r;
        r = OrdW'(IdxW);
        for (int i = IdxW - 1; i >= 0; i--) begin
            if (v[i]) r = OrdW'(i);
        end
        return r;
    endfunction

    function automatic logic [LinkW-1:0] f_pow(input logic [OrdW-1:0] k);
        return LinkW'(1) << k;
    endfunction

endpackage

[src/bpa_ram.sv]
`timescale 1ns / 1ps
// bpa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/bpa_ctrl.sv]
`timescale 1ns / 1ps
// bpa_ctrl: sequencer of the allocator; issues one step per cycle to the datapath.
// Depends on bpa_pkg.
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_valid
);
    import bpa_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_state rel_ret;

    assign rel_ret = (i_sts.act == ACT_INIT) ? S_INXT : S_DONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE: if (start) n_state = S_DECODE;
            S_DECODE: begin
                case (i_sts.act)
                    ACT_ALLOC: n_state = i_sts.dec_fail ? S_DONE : S_ASRCH;
                    ACT_FREE:  n_state = i_sts.dec_fail ? S_DONE : S_FCHK;
                    ACT_INIT:  n_state = S_ICLR;
                    default:   n_state = S_DONE;
                endcase
            end
            S_ASRCH: begin
                if (i_sts.srch_hit) begin
                    n_state = S_RMRD;
                    n_ret   = S_ASPL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ASPL: begin
                if (i_sts.spl_more) begin
                    n_state = S_PU1;
                    n_ret   = S_ASPL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RMRD: n_state = S_RMWR;
            S_RMWR: n_state = S_MARK;
            S_PU1:  n_state = S_PU2;
            S_PU2:  n_state = S_MARK;
            S_MARK: if (i_sts.mark_last) n_state = r_ret;
            S_FCHK: n_state = i_sts.fchk_ok ? S_RELT : S_DONE;
            S_RELT: begin
                if (i_sts.rel_stop) begin
                    n_state = S_PU1;
                    n_ret   = rel_ret;
                end else begin
                    n_state = S_RELC;
                end
            end
            S_RELC: begin
                if (i_sts.rel_merge) begin
                    n_state = S_RMRD;
                    n_ret   = S_RELM;
                end else begin
                    n_state = S_PU1;
                    n_ret   = rel_ret;
                end
            end
            S_RELM: n_state = S_RELT;
            S_ICLR: if (i_sts.clr_done) n_state = S_ISEL;
            S_ISEL: n_state = i_sts.rem_zero ? S_DONE : S_RELT;
            S_INXT: n_state = S_ISEL;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = r_state;
        o_cmd.accept = (r_state == S_IDLE) && start;
        busy         = (r_state != S_IDLE);
        o_valid      = (r_state == S_DONE);
    end

endmodule

[src/bpa_dp.sv]
`timescale 1ns / 1ps
// bpa_dp: allocator datapath: page table RAMs, free lists, counters, result registers.
// Depends on bpa_pkg and bpa_ram.
module bpa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpa_pkg::t_cmd                  i_cmd,
    input  logic [1:0]                     i_action,
    input  logic [bpa_pkg::SizeW-1:0]      i_size_bytes,
    input  logic [bpa_pkg::AddrW-1:0]      i_address,
    output bpa_pkg::t_sts                  o_sts,
    output logic [2:0]                     o_status,
    output logic [bpa_pkg::AddrW-1:0]      o_block_address,
    output logic [bpa_pkg::FreeW-1:0]      o_free_pages
);
    import bpa_pkg::*;

    t_action          r_act;
    logic [SizeW-1:0] r_size;
    logic [AddrW-1:0] r_addr;
    logic [AddrW-1:0] r_hstart;
    logic [LinkW-1:0] r_hpages;
    logic [LinkW-1:0] r_heads  [OrdN];
    logic [LinkW-1:0] r_counts [OrdN];
    logic [LinkW-1:0] r_free;
    t_status          r_status;
    logic [AddrW-1:0] r_baddr;
    logic [IdxW-1:0]  r_idx, r_bud, r_tgt;
    logic [OrdW-1:0]  r_k, r_want, r_tk;
    logic [LinkW-1:0] r_flo, r_mp, r_mend, r_pos, r_rem, r_ifl, r_isz;
    logic             r_mval;

    logic             fl_we, or_we, nx_we, pv_we;
    logic [IdxW-1:0]  fl_wa, or_wa, nx_wa, pv_wa, pg_ra;
    logic             fl_wd, fl_q;
    logic [OrdW-1:0]  or_wd, or_q;
    logic [LinkW-1:0] nx_wd, pv_wd, nx_q, pv_q;

    logic [SizeW:0]   pages_w;
    logic             too_big;
    logic [OrdW-1:0]  kcalc;
    logic [AddrW:0]   diff;
    logic [IdxW-1:0]  idx_c;
    logic             free_fail;
    logic [SizeW-PageSh-1:0] sz_pg;
    logic [LinkW-1:0] n_c;
    logic             hit;
    logic [OrdW-1:0]  csel;
    logic [LinkW-1:0] flo_c;
    logic             misal;
    logic [LinkW-1:0] pk, pk_tk, b_dn, b_up, mend_sum, mend_c;
    logic             lo_bit, bud_ok;
    logic [IdxW-1:0]  b_c;
    logic [OrdW-1:0]  kt, km, ks;
    logic [LinkW-1:0] head_tk;

    bpa_ram #(.Width(1), .Depth(MaxPages)) u_flag (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_wa), .i_wdata(fl_wd),
        .i_raddr(pg_ra), .o_rdata(fl_q)
    );
    bpa_ram #(.Width(OrdW), .Depth(MaxPages)) u_order (
        .i_clk(i_clk), .i_we(or_we), .i_waddr(or_wa), .i_wdata(or_wd),
        .i_raddr(pg_ra), .o_rdata(or_q)
    );
    bpa_ram #(.Width(LinkW), .Depth(MaxPages)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(r_tgt), .o_rdata(nx_q)
    );
    bpa_ram #(.Width(LinkW), .Depth(MaxPages)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(r_tgt), .o_rdata(pv_q)
    );

    always_comb begin
        pages_w   = ({1'b0, r_size} + (SizeW+1)'(PageBytes - 1)) >> PageSh;
        too_big   = pages_w > (SizeW+1)'(2 ** TopOrder);
        kcalc     = f_bitlen(IdxW'(pages_w - (SizeW+1)'(1)));
        diff      = {1'b0, r_addr} - {1'b0, r_hstart};
        idx_c     = diff[PageSh+IdxW-1:PageSh];
        free_fail = (r_addr == '0) || diff[AddrW] || (diff[AddrW-1:PageSh+IdxW] != '0)
                    || ({1'b0, idx_c} >= r_hpages);
        sz_pg     = r_size[SizeW-1:PageSh];
        n_c       = (sz_pg > (SizeW-PageSh)'(MaxPages)) ? LinkW'(MaxPages) : LinkW'(sz_pg);

        hit  = 1'b0;
        csel = '0;
        for (int c = TopOrder; c >= 0; c--) begin
            if ((OrdW'(c) >= r_want) && (r_counts[c] != '0) && (r_heads[c] < NoneLink)) begin
                hit  = 1'b1;
                csel = OrdW'(c);
            end
        end

        flo_c = LinkW'(r_hstart[PageSh+LinkW-1:PageSh]) + LinkW'(r_idx);
        misal = (flo_c & (f_pow(or_q) - LinkW'(1))) != '0;

        pk     = f_pow(r_k);
        pk_tk  = f_pow(r_tk);
        lo_bit = r_flo[r_k];
        b_dn   = {1'b0, r_idx} - pk;
        b_up   = {1'b0, r_idx} + pk;
        bud_ok = lo_bit ? ({1'b0, r_idx} >= pk) : (b_up < r_hpages);
        b_c    = lo_bit ? b_dn[IdxW-1:0] : b_up[IdxW-1:0];

        mend_sum = {1'b0, r_tgt} + pk_tk;
        mend_c   = (mend_sum > LinkW'(MaxPages)) ? LinkW'(MaxPages) : mend_sum;

        kt = f_tz(r_ifl[IdxW-1:0]);
        km = f_msb(r_rem);
        ks = (kt < km) ? kt : km;
        if (ks > OrdW'(TopOrder)) ks = OrdW'(TopOrder);

        head_tk = r_heads[r_tk];
    end

    always_comb begin
        o_sts.act       = r_act;
        case (r_act)
            ACT_ALLOC: o_sts.dec_fail = (r_size == '0) || too_big;
            ACT_FREE:  o_sts.dec_fail = free_fail;
            default:   o_sts.dec_fail = 1'b0;
        endcase
        o_sts.srch_hit  = hit;
        o_sts.spl_more  = r_k > r_want;
        o_sts.fchk_ok   = !fl_q && (or_q <= OrdW'(TopOrder)) && !misal;
        o_sts.clr_done  = (r_mp == r_hpages);
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.rel_stop  = (r_k >= OrdW'(TopOrder)) || !bud_ok;
        o_sts.rel_merge = fl_q && (or_q == r_k);
        o_sts.mark_last = (r_mp + LinkW'(1)) == r_mend;
    end

    always_comb begin
        fl_we = 1'b0; fl_wa = r_mp[IdxW-1:0]; fl_wd = 1'b0;
        or_we = 1'b0; or_wa = r_mp[IdxW-1:0]; or_wd = '0;
        nx_we = 1'b0; nx_wa = r_tgt;          nx_wd = '0;
        pv_we = 1'b0; pv_wa = r_tgt;          pv_wd = '0;
        pg_ra = (i_cmd.op == S_RELT) ? b_c : idx_c;
        case (i_cmd.op)
            S_RMWR: begin
                if (pv_q < NoneLink) begin
                    nx_we = 1'b1;
                    nx_wa = pv_q[IdxW-1:0];
                    nx_wd = nx_q;
                end
                if (nx_q < NoneLink) begin
                    pv_we = 1'b1;
                    pv_wa = nx_q[IdxW-1:0];
                    pv_wd = pv_q;
                end
            end
            S_MARK: begin
                fl_we = 1'b1;
                fl_wd = r_mval;
                or_we = r_mval;
                or_wd = r_tk;
            end
            S_PU1: begin
                nx_we = 1'b1;
                nx_wd = head_tk;
                pv_we = 1'b1;
                pv_wd = NoneLink;
            end
            S_PU2: begin
                if (head_tk < NoneLink) begin
                    pv_we = 1'b1;
                    pv_wa = head_tk[IdxW-1:0];
                    pv_wd = {1'b0, r_tgt};
                end
            end
            S_ASPL: begin
                if (!(r_k > r_want)) begin
                    or_we = 1'b1;
                    or_wa = r_idx;
                    or_wd = r_want;
                end
            end
            S_ICLR: begin
                if (r_mp != r_hpages) begin
                    fl_we = 1'b1;
                    or_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hstart <= '0;
            r_hpages <= '0;
            r_free   <= '0;
            for (int i = 0; i < OrdN; i++) begin
                r_heads[i]  <= NoneLink;
                r_counts[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                S_DECODE: begin
                    if (r_act == ACT_INIT) begin
                        r_hstart <= r_addr;
                        r_hpages <= n_c;
                        r_free   <= '0;
                        for (int i = 0; i < OrdN; i++) begin
                            r_heads[i]  <= NoneLink;
                            r_counts[i] <= '0;
                        end
                    end
                end
                S_RMWR: begin
                    if (pv_q >= NoneLink) r_heads[r_tk] <= nx_q;
                    r_counts[r_tk] <= r_counts[r_tk] - LinkW'(1);
                    r_free         <= r_free - pk_tk;
                end
                S_PU2: begin
                    r_heads[r_tk]  <= {1'b0, r_tgt};
                    r_counts[r_tk] <= r_counts[r_tk] + LinkW'(1);
                    r_free         <= r_free + pk_tk;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            S_IDLE: begin
                if (i_cmd.accept) begin
                    r_act    <= t_action'(i_action);
                    r_size   <= i_size_bytes;
                    r_addr   <= i_address;
                    r_baddr  <= '0;
                    r_status <= ST_DONE;
                end
            end
            S_DECODE: begin
                case (r_act)
                    ACT_ALLOC: begin
                        if (r_size == '0) r_status <= ST_ZERO;
                        else if (too_big) r_status <= ST_BIG;
                        r_want <= kcalc;
                    end
                    ACT_FREE: begin
                        if (free_fail) r_status <= ST_OUT;
                        r_idx <= idx_c;
                    end
                    ACT_INIT: begin
                        r_mp  <= '0;
                        r_pos <= '0;
                        r_rem <= n_c;
                        r_ifl <= r_addr[PageSh+LinkW-1:PageSh];
                    end
                    default: ;
                endcase
            end
            S_ASRCH: begin
                if (hit) begin
                    r_tgt <= r_heads[csel][IdxW-1:0];
                    r_idx <= r_heads[csel][IdxW-1:0];
                    r_tk  <= csel;
                    r_k   <= csel;
                end else begin
                    r_status <= ST_NOBLK;
                end
            end
            S_RMWR: begin
                r_mp   <= {1'b0, r_tgt};
                r_mend <= mend_c;
                r_mval <= 1'b0;
            end
            S_PU2: begin
                r_mp   <= {1'b0, r_tgt};
                r_mend <= mend_c;
                r_mval <= 1'b1;
            end
            S_MARK: r_mp <= r_mp + LinkW'(1);
            S_ASPL: begin
                if (r_k > r_want) begin
                    r_k   <= r_k - OrdW'(1);
                    r_tk  <= r_k - OrdW'(1);
                    r_tgt <= r_idx + IdxW'(f_pow(r_k - OrdW'(1)));
                end else begin
                    r_baddr <= r_hstart + (AddrW'(r_idx) << PageSh);
                end
            end
            S_FCHK: begin
                if (fl_q) begin
                    r_status <= ST_DFREE;
                end else if (!((or_q <= OrdW'(TopOrder)) && !misal)) begin
                    r_status <= ST_OUT;
                end else begin
                    r_k   <= or_q;
                    r_flo <= flo_c;
                end
            end
            S_RELT: begin
                r_bud <= b_c;
                r_tgt <= r_idx;
                r_tk  <= r_k;
            end
            S_RELC: begin
                r_tgt <= (fl_q && (or_q == r_k)) ? r_bud : r_idx;
                r_tk  <= r_k;
            end
            S_RELM: begin
                if (lo_bit) begin
                    r_idx <= r_bud;
                    r_flo <= r_flo - pk;
                end
                r_k <= r_k + OrdW'(1);
            end
            S_ICLR: if (r_mp != r_hpages) r_mp <= r_mp + LinkW'(1);
            S_ISEL: begin
                r_idx <= r_pos[IdxW-1:0];
                r_k   <= ks;
                r_flo <= r_ifl;
                r_isz <= f_pow(ks);
            end
            S_INXT: begin
                r_pos <= r_pos + r_isz;
                r_rem <= r_rem - r_isz;
                r_ifl <= r_ifl + r_isz;
            end
            default: ;
        endcase
    end

    assign o_status        = r_status;
    assign o_block_address = r_baddr;
    assign o_free_pages    = FreeW'(r_free);

endmodule

[src/buddy_page_allocator_unit.sv]
`timescale 1ns / 1ps
// buddy_page_allocator_unit: top level of the buddy page allocator.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp.
//
//  channel  | handshake      | beat
//  ---------+----------------+---------------------------------------------
//  command  | start / busy   | i_action, i_size_bytes, i_address
//  result   | o_valid strobe | o_status, o_block_address, o_free_pages
//
// One command at a time; busy stays high through the one-cycle result beat, never stalled.
// Allocate: decode, search, unlink the block and mark its pages, then per split push the
// upper half and mark it; refused at decode (zero or oversized) or search (none free).
// Free: check, merge with each free buddy, then push and mark the final block; refused at
// decode or check. Initialise: clear the page table, then one release per block.
// Synchronous reset empties all free lists and the heap; no clearing pass.
module buddy_page_allocator_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_action,
    input  logic [bpa_pkg::SizeW-1:0] i_size_bytes,
    input  logic [bpa_pkg::AddrW-1:0] i_address,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic [bpa_pkg::AddrW-1:0] o_block_address,
    output logic [bpa_pkg::FreeW-1:0] o_free_pages
);
    import bpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    bpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_size_bytes    (i_size_bytes),
        .i_address       (i_address),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_free_pages    (o_free_pages)
    );

endmodule

[src/bpa_checker.sv]
`timescale 1ns / 1ps
// bpa_checker: port-level assertions for the buddy page allocator, bound to the top.
// Depends on bpa_pkg.
module bpa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic [2:0]                o_status,
    input logic [bpa_pkg::AddrW-1:0] o_block_address,
    input logic [bpa_pkg::FreeW-1:0] o_free_pages
);
    import bpa_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result beat not single or busy held");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside a command");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != 3'(ST_DONE)) |-> o_block_address == '0)
        else $error("address given on failed command");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_pages <= FreeW'(MaxPages))
        else $error("free page count out of range");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_block_address (o_block_address),
    .o_free_pages    (o_free_pages)
);
